// ===== design/radl_pkg.sv =====
// Shared types, constants and helpers for the radial lens distortion map unit.
// Used by radl_ctrl, radl_dp and the top level; depends on nothing.
package radl_pkg;

  // Coordinate and coefficient formats
  localparam int COORD_W         = 32;
  localparam int COORD_FRAC_BITS = 24;
  localparam int K1_W            = 48;
  localparam int K1_FRAC         = 40;
  localparam int TOL_W           = 24;
  localparam int PASS_W          = 6;
  localparam int R2_W            = 40;
  localparam int FMAG_W          = 63;
  localparam int ACC_W           = 96;
  localparam int PROD_W          = 64;
  localparam int REM_W           = 64;
  localparam int QUO_W           = 33;
  localparam int STEP_W          = 7;
  localparam int CFG_IDX_W       = 2;

  // Divider runs one quotient bit per step over 32 integer and 40 fraction bits
  localparam int DIV_STEPS = COORD_W + K1_FRAC;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_K1        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PASS  = 2'd2;

  localparam logic [TOL_W-1:0]  TOL_RESET      = 24'd168;
  localparam logic [PASS_W-1:0] MAX_PASS_RESET = 6'd20;

  localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7fff_ffff;
  localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh8000_0000;

  // Multiplier operand pairs
  typedef enum logic [2:0] {
    MS_GX2 = 3'd0,
    MS_GY2 = 3'd1,
    MS_K00 = 3'd2,
    MS_K01 = 3'd3,
    MS_K10 = 3'd4,
    MS_K11 = 3'd5,
    MS_CF0 = 3'd6,
    MS_CF1 = 3'd7
  } mul_sel_t;

  // Accumulator operations on the registered product
  typedef enum logic [2:0] {
    ACC_HOLD  = 3'd0,
    ACC_LOAD  = 3'd1,
    ACC_ADD0  = 3'd2,
    ACC_ADD32 = 3'd3,
    ACC_ADD64 = 3'd4
  } acc_op_t;

  // Which values go to the output register
  typedef enum logic [1:0] {
    RES_FWD   = 2'd0,
    RES_GUESS = 2'd1,
    RES_FAIL  = 2'd2
  } res_sel_t;

  typedef struct packed {
    logic     load_in;
    mul_sel_t mul_sel;
    acc_op_t  acc_op;
    logic     coord_y;
    logic     latch_r2;
    logic     latch_f;
    logic     latch_u;
    logic     div_init;
    logic     div_step;
    logic     latch_g;
    logic     out_load;
    res_sel_t res_sel;
  } cmd_t;

  typedef struct packed {
    logic              conv;
    logic [PASS_W-1:0] max_passes;
  } stat_t;

  // Magnitude of a signed coordinate; the most negative value maps to 2^31
  function automatic logic [COORD_W-1:0] mag32(input logic signed [COORD_W-1:0] v);
    return v[COORD_W-1] ? (~v + 32'd1) : v;
  endfunction

  // Apply a sign to a magnitude and saturate to the coordinate range
  function automatic logic signed [COORD_W-1:0] sat_coord(input logic [63:0] m,
                                                          input logic neg);
    logic big;
    big = (m[63:COORD_W-1] != '0);
    if (neg) begin
      return big ? COORD_MIN : (~m[COORD_W-1:0] + 32'd1);
    end
    return big ? COORD_MAX : m[COORD_W-1:0];
  endfunction

endpackage

// ===== design/radial_lens_distortion_map_unit.sv =====
// Top level of the radial lens distortion map: joins radl_ctrl and radl_dp.
// Depends on radl_pkg, radl_ctrl and radl_dp.
//
//   channel   handshake              payload
//   request   in_valid / in_stall    in_action, in_x, in_y
//   result    out_valid / out_stall  out_x, out_y, out_ok
//   config    cfg_we                 cfg_index, cfg_wdata
//
// Forward map: each request runs the square sum, the k1*r^2 factor over four
// partial products, then two coordinate products on the shared 32x32 multiplier.
// Inverse: each pass is dominated by the 72-step bit-serial divider that runs
// both coordinates side by side.
// Reset is synchronous and active low; it restores the register defaults.
// A new request is taken while the previous result still waits in the output
// register; a finished request waits for that register to free up.
module radial_lens_distortion_map_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [radl_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [radl_pkg::K1_W-1:0]            cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_action,
  input  logic signed [radl_pkg::COORD_W-1:0]  in_x,
  input  logic signed [radl_pkg::COORD_W-1:0]  in_y,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [radl_pkg::COORD_W-1:0]  out_x,
  output logic signed [radl_pkg::COORD_W-1:0]  out_y,
  output logic                                 out_ok
);

  radl_pkg::cmd_t  cmd;
  radl_pkg::stat_t stat;

  radl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_action),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  radl_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_x      (in_x),
    .in_y      (in_y),
    .cmd       (cmd),
    .stat      (stat),
    .out_x     (out_x),
    .out_y     (out_y),
    .out_ok    (out_ok)
  );

endmodule

// ===== design/radl_dp.sv =====
// Datapath: configuration registers, shared 32x32 multiplier with accumulator,
// two-lane restoring divider, and the output register. Uses radl_pkg.
module radl_dp (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [radl_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [radl_pkg::K1_W-1:0]             cfg_wdata,
  input  logic signed [radl_pkg::COORD_W-1:0]   in_x,
  input  logic signed [radl_pkg::COORD_W-1:0]   in_y,
  input  radl_pkg::cmd_t                        cmd,
  output radl_pkg::stat_t                       stat,
  output logic signed [radl_pkg::COORD_W-1:0]   out_x,
  output logic signed [radl_pkg::COORD_W-1:0]   out_y,
  output logic                                  out_ok
);

  // Configuration
  logic signed [radl_pkg::K1_W-1:0]  k1_r;
  logic [radl_pkg::TOL_W-1:0]        tol_r;
  logic [radl_pkg::PASS_W-1:0]       maxp_r;

  // Working values
  logic signed [radl_pkg::COORD_W-1:0] x_r, y_r, gx_r, gy_r, ux_r, uy_r;
  logic [radl_pkg::PROD_W-1:0]         p_r;
  logic [radl_pkg::ACC_W-1:0]          acc_r, acc_nxt;
  logic [radl_pkg::R2_W-1:0]           r2_r;
  logic [radl_pkg::FMAG_W-1:0]         fmag_r;
  logic                                fneg_r;
  logic [radl_pkg::REM_W-1:0]          remx_r, remy_r, remx_nxt, remy_nxt;
  logic [radl_pkg::COORD_W-1:0]        nx_r, ny_r;
  logic [radl_pkg::QUO_W-1:0]          qx_r, qy_r, qx_nxt, qy_nxt;
  logic signed [radl_pkg::COORD_W-1:0] out_x_r, out_y_r;
  logic                                out_ok_r;

  logic [radl_pkg::COORD_W-1:0]  gxm, gym, cm, mul_a, mul_b;
  logic                          cneg;
  logic [radl_pkg::K1_W-1:0]     ka;
  logic [radl_pkg::FMAG_W-1:0]   pv;
  logic signed [63:0]            fs;
  logic [63:0]                   fs_abs;
  logic signed [radl_pkg::COORD_W-1:0] u_val, gx_val, gy_val;
  logic signed [radl_pkg::COORD_W:0]   dx, dy;
  logic [radl_pkg::COORD_W:0]          dxm, dym;
  logic                                fzero;

  localparam logic [radl_pkg::QUO_W-1:0] QCAP = 33'h1_0000_0000;
  localparam logic signed [63:0] ONE = 64'sd1 <<< radl_pkg::K1_FRAC;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k1_r   <= '0;
      tol_r  <= radl_pkg::TOL_RESET;
      maxp_r <= radl_pkg::MAX_PASS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        radl_pkg::CFG_K1:        k1_r   <= cfg_wdata;
        radl_pkg::CFG_TOLERANCE: tol_r  <= cfg_wdata[radl_pkg::TOL_W-1:0];
        radl_pkg::CFG_MAX_PASS:  maxp_r <= cfg_wdata[radl_pkg::PASS_W-1:0];
        default: ;
      endcase
    end
  end

  // Select multiplier operands
  always_comb begin
    gxm  = radl_pkg::mag32(gx_r);
    gym  = radl_pkg::mag32(gy_r);
    cm   = cmd.coord_y ? gym : gxm;
    cneg = cmd.coord_y ? gy_r[radl_pkg::COORD_W-1] : gx_r[radl_pkg::COORD_W-1];
    ka   = k1_r[radl_pkg::K1_W-1] ? (~k1_r + 48'd1) : k1_r;
    case (cmd.mul_sel)
      radl_pkg::MS_GX2: begin mul_a = gxm; mul_b = gxm; end
      radl_pkg::MS_GY2: begin mul_a = gym; mul_b = gym; end
      radl_pkg::MS_K00: begin mul_a = ka[31:0]; mul_b = r2_r[31:0]; end
      radl_pkg::MS_K01: begin mul_a = ka[31:0]; mul_b = {24'd0, r2_r[39:32]}; end
      radl_pkg::MS_K10: begin mul_a = {16'd0, ka[47:32]}; mul_b = r2_r[31:0]; end
      radl_pkg::MS_K11: begin mul_a = {16'd0, ka[47:32]}; mul_b = {24'd0, r2_r[39:32]}; end
      radl_pkg::MS_CF0: begin mul_a = cm; mul_b = fmag_r[31:0]; end
      radl_pkg::MS_CF1: begin mul_a = cm; mul_b = {1'b0, fmag_r[62:32]}; end
      default:          begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // Accumulate shifted partial products
  always_comb begin
    case (cmd.acc_op)
      radl_pkg::ACC_LOAD:  acc_nxt = {32'd0, p_r};
      radl_pkg::ACC_ADD0:  acc_nxt = acc_r + {32'd0, p_r};
      radl_pkg::ACC_ADD32: acc_nxt = acc_r + {p_r, 32'd0};
      radl_pkg::ACC_ADD64: acc_nxt = acc_r + {p_r[31:0], 64'd0};
      default:             acc_nxt = acc_r;
    endcase
  end

  // Form the radial factor from the accumulated k1*r2 product
  always_comb begin
    pv     = acc_r[radl_pkg::COORD_FRAC_BITS+62:radl_pkg::COORD_FRAC_BITS];
    fs     = k1_r[radl_pkg::K1_W-1] ? (ONE - signed'({1'b0, pv}))
                                    : (ONE + signed'({1'b0, pv}));
    fs_abs = fs[63] ? (~fs + 64'd1) : fs;
    u_val  = radl_pkg::sat_coord({9'd0, acc_r[94:40]}, cneg ^ fneg_r);
  end

  // Restoring division step on both lanes
  always_comb begin
    logic [radl_pkg::REM_W-1:0] tx, ty;
    logic gex, gey;
    tx  = {remx_r[62:0], nx_r[radl_pkg::COORD_W-1]};
    ty  = {remy_r[62:0], ny_r[radl_pkg::COORD_W-1]};
    gex = tx >= {1'b0, fmag_r};
    gey = ty >= {1'b0, fmag_r};
    remx_nxt = gex ? (tx - {1'b0, fmag_r}) : tx;
    remy_nxt = gey ? (ty - {1'b0, fmag_r}) : ty;
    qx_nxt = ((qx_r >= QCAP) ? QCAP : {qx_r[31:0], 1'b0}) | {32'd0, gex};
    qy_nxt = ((qy_r >= QCAP) ? QCAP : {qy_r[31:0], 1'b0}) | {32'd0, gey};
  end

  // Signed guess from the quotients; zero factor saturates toward the input sign
  always_comb begin
    fzero = (fmag_r == '0);
    if (fzero) begin
      gx_val = x_r[radl_pkg::COORD_W-1] ? radl_pkg::COORD_MIN : radl_pkg::COORD_MAX;
      gy_val = y_r[radl_pkg::COORD_W-1] ? radl_pkg::COORD_MIN : radl_pkg::COORD_MAX;
    end else begin
      gx_val = radl_pkg::sat_coord({31'd0, qx_r}, x_r[radl_pkg::COORD_W-1] ^ fneg_r);
      gy_val = radl_pkg::sat_coord({31'd0, qy_r}, y_r[radl_pkg::COORD_W-1] ^ fneg_r);
    end
  end

  // Convergence test against tolerance
  always_comb begin
    dx  = {ux_r[radl_pkg::COORD_W-1], ux_r} - {x_r[radl_pkg::COORD_W-1], x_r};
    dy  = {uy_r[radl_pkg::COORD_W-1], uy_r} - {y_r[radl_pkg::COORD_W-1], y_r};
    dxm = dx[radl_pkg::COORD_W] ? (~dx + 33'd1) : dx;
    dym = dy[radl_pkg::COORD_W] ? (~dy + 33'd1) : dy;
    stat.conv       = (dxm <= {9'd0, tol_r}) && (dym <= {9'd0, tol_r});
    stat.max_passes = maxp_r;
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    p_r   <= mul_a * mul_b;
    acc_r <= acc_nxt;
    if (cmd.load_in) begin
      x_r  <= in_x;
      y_r  <= in_y;
      gx_r <= in_x;
      gy_r <= in_y;
    end
    if (cmd.latch_r2) begin
      r2_r <= acc_r[radl_pkg::COORD_FRAC_BITS+radl_pkg::R2_W-1:radl_pkg::COORD_FRAC_BITS];
    end
    if (cmd.latch_f) begin
      fmag_r <= fs_abs[radl_pkg::FMAG_W-1:0];
      fneg_r <= fs[63];
    end
    if (cmd.latch_u) begin
      if (cmd.coord_y) begin
        uy_r <= u_val;
      end else begin
        ux_r <= u_val;
      end
    end
    if (cmd.div_init) begin
      remx_r <= '0;
      remy_r <= '0;
      nx_r   <= radl_pkg::mag32(x_r);
      ny_r   <= radl_pkg::mag32(y_r);
      qx_r   <= '0;
      qy_r   <= '0;
    end else if (cmd.div_step) begin
      remx_r <= remx_nxt;
      remy_r <= remy_nxt;
      nx_r   <= {nx_r[radl_pkg::COORD_W-2:0], 1'b0};
      ny_r   <= {ny_r[radl_pkg::COORD_W-2:0], 1'b0};
      qx_r   <= qx_nxt;
      qy_r   <= qy_nxt;
    end
    if (cmd.latch_g) begin
      gx_r <= gx_val;
      gy_r <= gy_val;
    end
    if (cmd.out_load) begin
      case (cmd.res_sel)
        radl_pkg::RES_FWD: begin
          out_x_r <= ux_r; out_y_r <= uy_r; out_ok_r <= 1'b1;
        end
        radl_pkg::RES_GUESS: begin
          out_x_r <= gx_r; out_y_r <= gy_r; out_ok_r <= 1'b1;
        end
        default: begin
          out_x_r <= '0; out_y_r <= '0; out_ok_r <= 1'b0;
        end
      endcase
    end
  end

  assign out_x  = out_x_r;
  assign out_y  = out_y_r;
  assign out_ok = out_ok_r;

endmodule

// ===== design/radl_ctrl.sv =====
// Controller: sequences the multiply, divide and check steps of one request
// and runs the request and result handshakes. Uses radl_pkg.
module radl_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_action,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  input  radl_pkg::stat_t stat,
  output radl_pkg::cmd_t  cmd
);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_SQ    = 7'b0000010,
    ST_FAC   = 7'b0000100,
    ST_FWD   = 7'b0001000,
    ST_CHECK = 7'b0010000,
    ST_DIV   = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_t;

  localparam logic [radl_pkg::STEP_W-1:0] DIV_LAST = radl_pkg::STEP_W'(radl_pkg::DIV_STEPS + 1);

  state_t                         state_r, state_nxt;
  logic [radl_pkg::STEP_W-1:0]    step_r, step_nxt;
  logic [radl_pkg::PASS_W-1:0]    pass_r, pass_nxt;
  logic                           action_r, action_nxt;
  logic                           passing_r, passing_nxt;
  radl_pkg::res_sel_t             res_r, res_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic                           out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  // Sequence the datapath
  always_comb begin
    cmd         = '0;
    state_nxt   = state_r;
    step_nxt    = step_r;
    pass_nxt    = pass_r;
    action_nxt  = action_r;
    passing_nxt = passing_r;
    res_nxt     = res_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          action_nxt  = in_action;
          pass_nxt    = '0;
          passing_nxt = 1'b0;
          step_nxt    = '0;
          state_nxt   = ST_SQ;
        end
      end
      ST_SQ: begin
        step_nxt = step_r + 7'd1;
        case (step_r[1:0])
          2'd0: cmd.mul_sel = radl_pkg::MS_GX2;
          2'd1: begin
            cmd.mul_sel = radl_pkg::MS_GY2;
            cmd.acc_op  = radl_pkg::ACC_LOAD;
          end
          2'd2: cmd.acc_op = radl_pkg::ACC_ADD0;
          default: begin
            cmd.latch_r2 = 1'b1;
            step_nxt     = '0;
            state_nxt    = ST_FAC;
          end
        endcase
      end
      ST_FAC: begin
        step_nxt = step_r + 7'd1;
        case (step_r[2:0])
          3'd0: cmd.mul_sel = radl_pkg::MS_K00;
          3'd1: begin
            cmd.mul_sel = radl_pkg::MS_K01;
            cmd.acc_op  = radl_pkg::ACC_LOAD;
          end
          3'd2: begin
            cmd.mul_sel = radl_pkg::MS_K10;
            cmd.acc_op  = radl_pkg::ACC_ADD32;
          end
          3'd3: begin
            cmd.mul_sel = radl_pkg::MS_K11;
            cmd.acc_op  = radl_pkg::ACC_ADD32;
          end
          3'd4: cmd.acc_op = radl_pkg::ACC_ADD64;
          default: begin
            cmd.latch_f = 1'b1;
            step_nxt    = '0;
            if (!action_r || passing_r) begin
              state_nxt = ST_FWD;
            end else if (stat.max_passes == '0) begin
              res_nxt   = radl_pkg::RES_FAIL;
              state_nxt = ST_DONE;
            end else begin
              state_nxt = ST_DIV;
            end
          end
        endcase
      end
      ST_FWD: begin
        step_nxt    = step_r + 7'd1;
        cmd.coord_y = step_r[2];
        case (step_r[1:0])
          2'd0: cmd.mul_sel = radl_pkg::MS_CF0;
          2'd1: begin
            cmd.mul_sel = radl_pkg::MS_CF1;
            cmd.acc_op  = radl_pkg::ACC_LOAD;
          end
          2'd2: cmd.acc_op = radl_pkg::ACC_ADD32;
          default: begin
            cmd.latch_u = 1'b1;
            if (step_r[2]) begin
              step_nxt = '0;
              if (!action_r) begin
                res_nxt   = radl_pkg::RES_FWD;
                state_nxt = ST_DONE;
              end else begin
                state_nxt = ST_CHECK;
              end
            end
          end
        endcase
      end
      ST_CHECK: begin
        if (stat.conv) begin
          res_nxt   = radl_pkg::RES_GUESS;
          state_nxt = ST_DONE;
        end else if (pass_r + 6'd1 == stat.max_passes) begin
          res_nxt   = radl_pkg::RES_FAIL;
          state_nxt = ST_DONE;
        end else begin
          pass_nxt  = pass_r + 6'd1;
          step_nxt  = '0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        step_nxt = step_r + 7'd1;
        if (step_r == '0) begin
          cmd.div_init = 1'b1;
        end else if (step_r == DIV_LAST) begin
          cmd.latch_g = 1'b1;
          passing_nxt = 1'b1;
          step_nxt    = '0;
          state_nxt   = ST_SQ;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          cmd.res_sel  = res_r;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Hold the result valid until taken
  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      pass_r      <= '0;
      action_r    <= 1'b0;
      passing_r   <= 1'b0;
      res_r       <= radl_pkg::RES_FAIL;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      pass_r      <= pass_nxt;
      action_r    <= action_nxt;
      passing_r   <= passing_nxt;
      res_r       <= res_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
